// ===== hw/rtl/rthsl_pkg.sv =====
// ----------------------------------------------------------------------------
// rthsl_pkg
// Shared widths and the divider pipeline payload of the RGB to HSL converter.
// ----------------------------------------------------------------------------
package rthsl_pkg;

  localparam int unsigned PixW      = 8;
  localparam int unsigned HueRemW   = 18;
  localparam int unsigned HueDivW   = 9;
  localparam int unsigned HueQW     = 9;
  localparam int unsigned SatRemW   = 17;
  localparam int unsigned SatDivW   = 8;
  localparam int unsigned SatQW     = 8;
  localparam int unsigned DivSteps  = HueQW;
  localparam int unsigned ScaleW    = 13;
  localparam int unsigned ScaleShW  = 10;
  localparam int unsigned RecipW    = 20;
  localparam int unsigned RecipMul  = 683;
  localparam int unsigned RecipSh   = 11;

  typedef struct packed {
    logic [HueRemW-1:0]  hue_rem;
    logic [HueDivW-1:0]  hue_div;
    logic [HueQW-1:0]    hue_q;
    logic                hue_zero;
    logic [SatRemW-1:0]  sat_rem;
    logic [SatDivW-1:0]  sat_div;
    logic [SatQW-1:0]    sat_q;
    logic                sat_zero;
    logic [PixW-1:0]     light;
  } div_t;

endpackage

// ===== hw/rtl/rthsl_prep.sv =====
// ----------------------------------------------------------------------------
// rthsl_prep
// Two stages: channel max and min, then hue and saturation operands.
// ----------------------------------------------------------------------------
module rthsl_prep
  import rthsl_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  logic [PixW-1:0] red_i,
  input  logic [PixW-1:0] green_i,
  input  logic [PixW-1:0] blue_i,
  output logic            valid_o,
  output div_t            data_o
);

  logic            va_q;
  logic [PixW-1:0] r_q, g_q, b_q, hi_q, lo_q;
  logic [PixW-1:0] hi_d, lo_d;
  logic            vb_q;
  div_t            data_d, data_q;

  logic [PixW-1:0]    chroma;
  logic [PixW:0]      sum;
  logic [HueRemW-1:0] c18, num;
  logic [PixW:0]      sat_den;

  always_comb begin
    hi_d = red_i;
    lo_d = red_i;
    if (green_i > hi_d) hi_d = green_i;
    if (blue_i > hi_d)  hi_d = blue_i;
    if (green_i < lo_d) lo_d = green_i;
    if (blue_i < lo_d)  lo_d = blue_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      va_q <= valid_i;
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q    <= red_i;
    g_q    <= green_i;
    b_q    <= blue_i;
    hi_q   <= hi_d;
    lo_q   <= lo_d;
    data_q <= data_d;
  end

  always_comb begin
    chroma = hi_q - lo_q;
    sum    = {1'b0, hi_q} + {1'b0, lo_q};
    c18    = HueRemW'(chroma);
    if (hi_q == r_q) begin
      if (g_q >= b_q) num = HueRemW'(60) * HueRemW'(g_q - b_q);
      else            num = HueRemW'(360) * c18 - HueRemW'(60) * HueRemW'(b_q - g_q);
    end else if (hi_q == g_q) begin
      num = HueRemW'(120) * c18 + HueRemW'(60) * HueRemW'(b_q) - HueRemW'(60) * HueRemW'(r_q);
    end else begin
      num = HueRemW'(240) * c18 + HueRemW'(60) * HueRemW'(r_q) - HueRemW'(60) * HueRemW'(g_q);
    end
    sat_den = (sum < 9'd255) ? sum : (9'd510 - sum);

    data_d          = '0;
    data_d.hue_rem  = {num[HueRemW-2:0], 1'b0} + c18;
    data_d.hue_div  = {chroma, 1'b0};
    data_d.hue_zero = (chroma == '0);
    data_d.sat_rem  = SatRemW'(chroma) * SatRemW'(255);
    data_d.sat_div  = sat_den[SatDivW-1:0];
    data_d.sat_zero = (chroma == '0) || (sum == 9'd0) || (sum == 9'd510);
    data_d.light    = sum[PixW:1];
  end

  assign valid_o = vb_q;
  assign data_o  = data_q;

endmodule

// ===== hw/rtl/rthsl_div_stage.sv =====
// ----------------------------------------------------------------------------
// rthsl_div_stage
// One registered restoring-division step for the hue and saturation quotients.
// ----------------------------------------------------------------------------
module rthsl_div_stage
  import rthsl_pkg::*;
#(
  parameter int unsigned STEP = 0
)
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  input  div_t data_i,
  output logic valid_o,
  output div_t data_o
);

  logic [HueRemW-1:0] hue_sh;
  logic [SatRemW-1:0] sat_sh;
  div_t               data_d, data_q;
  logic               valid_q;

  always_comb begin
    hue_sh = HueRemW'(data_i.hue_div) << STEP;
    sat_sh = SatRemW'(data_i.sat_div) << STEP;
    data_d = data_i;
    if (data_i.hue_rem >= hue_sh) begin
      data_d.hue_rem     = data_i.hue_rem - hue_sh;
      data_d.hue_q[STEP] = 1'b1;
    end
    if (STEP < SatQW) begin
      if (data_i.sat_rem >= sat_sh) begin
        data_d.sat_rem = data_i.sat_rem - sat_sh;
        data_d.sat_q[STEP % SatQW] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== hw/rtl/rthsl_post.sv =====
// ----------------------------------------------------------------------------
// rthsl_post
// Scale hue degrees by 255/360 with rounding over two stages; drive results.
// ----------------------------------------------------------------------------
module rthsl_post
  import rthsl_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  div_t            data_i,
  output logic            done_o,
  output logic [PixW-1:0] hue_code_o,
  output logic [PixW-1:0] saturation_code_o,
  output logic [PixW-1:0] lightness_code_o
);

  logic [HueQW-1:0]    deg;
  logic [ScaleW-1:0]   scaled;
  logic [ScaleShW-1:0] y_q;
  logic [PixW-1:0]     sat_q1, light_q1;
  logic                v1_q, v2_q;
  logic [RecipW-1:0]   prod;
  logic [PixW-1:0]     hue_q, sat_q2, light_q2;

  always_comb begin
    deg    = data_i.hue_zero ? '0 : data_i.hue_q;
    scaled = ScaleW'(deg) * ScaleW'(17) + ScaleW'(12);
    prod   = RecipW'(y_q) * RecipW'(RecipMul);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    y_q      <= scaled[ScaleW-1:3];
    sat_q1   <= data_i.sat_zero ? '0 : data_i.sat_q;
    light_q1 <= data_i.light;
    hue_q    <= prod[RecipSh +: PixW];
    sat_q2   <= sat_q1;
    light_q2 <= light_q1;
  end

  assign done_o            = v2_q;
  assign hue_code_o        = hue_q;
  assign saturation_code_o = sat_q2;
  assign lightness_code_o  = light_q2;

endmodule

// ===== hw/rtl/rgb_to_hsl_pixel.sv =====
// ----------------------------------------------------------------------------
// rgb_to_hsl_pixel
// RGB to HSL pixel converter, fully pipelined.
// ----------------------------------------------------------------------------
// Channel  Handshake         Payload
// input    start_i / busy_o  red_i, green_i, blue_i
// result   done_o            hue_code_o, saturation_code_o, lightness_code_o
//
// One pixel per cycle; each result passes the two operand stages, nine divider steps
// and two scaling stages before it appears on done_o.
// busy_o is always low; the receiver cannot stall, so nothing is held back.
// Reset clears the valid bits only.
// ----------------------------------------------------------------------------
module rgb_to_hsl_pixel
  import rthsl_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  output logic            busy_o,
  input  logic [PixW-1:0] red_i,
  input  logic [PixW-1:0] green_i,
  input  logic [PixW-1:0] blue_i,
  output logic            done_o,
  output logic [PixW-1:0] hue_code_o,
  output logic [PixW-1:0] saturation_code_o,
  output logic [PixW-1:0] lightness_code_o
);

  logic valid_s [DivSteps+1];
  div_t data_s  [DivSteps+1];

  assign busy_o = 1'b0;

  rthsl_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start_i && !busy_o),
    .red_i   (red_i),
    .green_i (green_i),
    .blue_i  (blue_i),
    .valid_o (valid_s[0]),
    .data_o  (data_s[0])
  );

  for (genvar i = 0; i < DivSteps; i++) begin : g_div
    rthsl_div_stage #(
      .STEP (DivSteps - 1 - i)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_s[i]),
      .data_i  (data_s[i]),
      .valid_o (valid_s[i+1]),
      .data_o  (data_s[i+1])
    );
  end

  rthsl_post u_post (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .valid_i           (valid_s[DivSteps]),
    .data_i            (data_s[DivSteps]),
    .done_o            (done_o),
    .hue_code_o        (hue_code_o),
    .saturation_code_o (saturation_code_o),
    .lightness_code_o  (lightness_code_o)
  );

endmodule
